// File: rtl/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg: session sequencer types and constants
// State codes, cause and action codes, register indexes, budget reset values
// and the fixed transition, budget and recovery tables.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int unsigned STATE_W  = 5;
   localparam int unsigned CAUSE_W  = 4;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned BUDGET_W = 48;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [STATE_W-1:0] NUM_STATES = 5'd19;

   localparam logic [STATE_W-1:0] ST_OFF            = 5'd0;
   localparam logic [STATE_W-1:0] ST_STARTING       = 5'd1;
   localparam logic [STATE_W-1:0] ST_HOST_VALIDATE  = 5'd2;
   localparam logic [STATE_W-1:0] ST_CAPS_RESOLVE   = 5'd3;
   localparam logic [STATE_W-1:0] ST_INPUT_ACQUIRE  = 5'd4;
   localparam logic [STATE_W-1:0] ST_SHELL_STARTING = 5'd5;
   localparam logic [STATE_W-1:0] ST_SHELL_ACTIVE   = 5'd6;
   localparam logic [STATE_W-1:0] ST_TITLE_REQUEST  = 5'd7;
   localparam logic [STATE_W-1:0] ST_TITLE_VALIDATE = 5'd8;
   localparam logic [STATE_W-1:0] ST_TITLE_STARTING = 5'd9;
   localparam logic [STATE_W-1:0] ST_TITLE_ACTIVE   = 5'd10;
   localparam logic [STATE_W-1:0] ST_TITLE_STOPPING = 5'd11;
   localparam logic [STATE_W-1:0] ST_TITLE_SUSPEND  = 5'd12;
   localparam logic [STATE_W-1:0] ST_TITLE_RESUMING = 5'd13;
   localparam logic [STATE_W-1:0] ST_TITLE_CRASHED  = 5'd14;
   localparam logic [STATE_W-1:0] ST_SHELL_RECOVER  = 5'd15;
   localparam logic [STATE_W-1:0] ST_RECOVERY       = 5'd16;
   localparam logic [STATE_W-1:0] ST_SESSION_EXIT   = 5'd17;
   localparam logic [STATE_W-1:0] ST_SAFE_MODE      = 5'd18;

   localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 4'd9;

   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_CHECK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_SHORT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_BRINGUP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_LONG    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_RECOVER = 2'd3;

   localparam logic [BUDGET_W-1:0] RST_BUDGET_SHORT   = 48'd5000000000;
   localparam logic [BUDGET_W-1:0] RST_BUDGET_BRINGUP = 48'd15000000000;
   localparam logic [BUDGET_W-1:0] RST_BUDGET_LONG    = 48'd30000000000;
   localparam logic [BUDGET_W-1:0] RST_BUDGET_RECOVER = 48'd10000000000;

   localparam logic [2:0] BC_NONE    = 3'd0;
   localparam logic [2:0] BC_SHORT   = 3'd1;
   localparam logic [2:0] BC_BRINGUP = 3'd2;
   localparam logic [2:0] BC_LONG    = 3'd3;
   localparam logic [2:0] BC_RECOVER = 3'd4;

   typedef struct packed {
      logic                accepted;
      logic                journal_valid;
      logic [STATE_W-1:0]  prior_state;
      logic [STATE_W-1:0]  new_state;
      logic [CAUSE_W-1:0]  cause_out;
      logic [TIME_W-1:0]   stamp_ns;
      logic [TIME_W-1:0]   tag_out;
      logic [BUDGET_W-1:0] deadline_ns;
      logic                expired;
   } rsp_word_type;

   typedef struct packed {
      logic               take;
      logic [STATE_W-1:0] state;
      logic [TIME_W-1:0]  entered_ns;
   } state_update_type;

   function automatic logic [31:0] state_bit(input logic [STATE_W-1:0] s);
      return 32'd1 << s;
   endfunction

   function automatic logic [31:0] legal_next(input logic [STATE_W-1:0] s);
      logic [31:0] m;
      m = '0;
      unique case (s)
         ST_OFF:            m = state_bit(ST_STARTING);
         ST_STARTING:       m = state_bit(ST_HOST_VALIDATE) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SESSION_EXIT);
         ST_HOST_VALIDATE:  m = state_bit(ST_CAPS_RESOLVE) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SESSION_EXIT) | state_bit(ST_SAFE_MODE);
         ST_CAPS_RESOLVE:   m = state_bit(ST_INPUT_ACQUIRE) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SESSION_EXIT);
         ST_INPUT_ACQUIRE:  m = state_bit(ST_SHELL_STARTING) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SESSION_EXIT);
         ST_SHELL_STARTING: m = state_bit(ST_SHELL_ACTIVE) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SESSION_EXIT);
         ST_SHELL_ACTIVE:   m = state_bit(ST_TITLE_REQUEST) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SESSION_EXIT) | state_bit(ST_SAFE_MODE);
         ST_TITLE_REQUEST:  m = state_bit(ST_TITLE_VALIDATE) | state_bit(ST_SHELL_ACTIVE);
         ST_TITLE_VALIDATE: m = state_bit(ST_TITLE_STARTING) | state_bit(ST_SHELL_ACTIVE);
         ST_TITLE_STARTING: m = state_bit(ST_TITLE_ACTIVE) | state_bit(ST_TITLE_CRASHED)
                              | state_bit(ST_SHELL_RECOVER) | state_bit(ST_RECOVERY);
         ST_TITLE_ACTIVE:   m = state_bit(ST_TITLE_STOPPING) | state_bit(ST_TITLE_SUSPEND)
                              | state_bit(ST_TITLE_CRASHED) | state_bit(ST_SHELL_RECOVER)
                              | state_bit(ST_RECOVERY);
         ST_TITLE_STOPPING: m = state_bit(ST_SHELL_RECOVER) | state_bit(ST_TITLE_CRASHED);
         ST_TITLE_SUSPEND:  m = state_bit(ST_TITLE_RESUMING) | state_bit(ST_TITLE_STOPPING)
                              | state_bit(ST_TITLE_CRASHED);
         ST_TITLE_RESUMING: m = state_bit(ST_TITLE_ACTIVE) | state_bit(ST_TITLE_CRASHED)
                              | state_bit(ST_SHELL_RECOVER);
         ST_TITLE_CRASHED:  m = state_bit(ST_SHELL_RECOVER) | state_bit(ST_RECOVERY);
         ST_SHELL_RECOVER:  m = state_bit(ST_SHELL_ACTIVE) | state_bit(ST_RECOVERY)
                              | state_bit(ST_SAFE_MODE);
         ST_RECOVERY:       m = state_bit(ST_SHELL_ACTIVE) | state_bit(ST_SESSION_EXIT)
                              | state_bit(ST_SAFE_MODE);
         default:           m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [2:0] budget_class(input logic [STATE_W-1:0] s);
      logic [2:0] c;
      c = BC_NONE;
      unique case (s)
         ST_STARTING, ST_INPUT_ACQUIRE, ST_SHELL_STARTING, ST_TITLE_VALIDATE:
            c = BC_SHORT;
         ST_HOST_VALIDATE, ST_CAPS_RESOLVE:
            c = BC_BRINGUP;
         ST_TITLE_STARTING, ST_RECOVERY:
            c = BC_LONG;
         ST_TITLE_STOPPING, ST_TITLE_RESUMING, ST_SHELL_RECOVER:
            c = BC_RECOVER;
         default:
            c = BC_NONE;
      endcase
      return c;
   endfunction

   function automatic logic has_recovery(input logic [STATE_W-1:0] s);
      logic h;
      h = 1'b0;
      unique case (s)
         ST_STARTING, ST_HOST_VALIDATE, ST_CAPS_RESOLVE, ST_INPUT_ACQUIRE,
         ST_SHELL_STARTING, ST_TITLE_REQUEST, ST_TITLE_VALIDATE, ST_TITLE_STARTING,
         ST_TITLE_STOPPING, ST_TITLE_RESUMING, ST_TITLE_CRASHED, ST_SHELL_RECOVER:
            h = 1'b1;
         default:
            h = 1'b0;
      endcase
      return h;
   endfunction

   function automatic logic [STATE_W-1:0] recovery_to(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0] t;
      t = ST_OFF;
      unique case (s)
         ST_TITLE_REQUEST, ST_TITLE_VALIDATE:
            t = ST_SHELL_ACTIVE;
         ST_STARTING, ST_HOST_VALIDATE, ST_CAPS_RESOLVE, ST_INPUT_ACQUIRE,
         ST_SHELL_STARTING, ST_TITLE_STARTING, ST_TITLE_STOPPING, ST_TITLE_RESUMING,
         ST_TITLE_CRASHED, ST_SHELL_RECOVER:
            t = ST_RECOVERY;
         default:
            t = ST_OFF;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// File: rtl/ssd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_if: session sequencer channel interfaces
// Request channel and response channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface ssd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ssd_pkg::STATE_W-1:0]   target_state;
   logic [ssd_pkg::CAUSE_W-1:0]   cause;
   logic [ssd_pkg::TIME_W-1:0]    now_ns;
   logic [ssd_pkg::TIME_W-1:0]    request_tag;

   modport source (output valid, action, target_state, cause, now_ns, request_tag,
                   input ready);
   modport sink (input valid, action, target_state, cause, now_ns, request_tag,
                 output ready);
endinterface

interface ssd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic                          journal_valid;
   logic [ssd_pkg::STATE_W-1:0]   prior_state;
   logic [ssd_pkg::STATE_W-1:0]   new_state;
   logic [ssd_pkg::CAUSE_W-1:0]   cause_out;
   logic [ssd_pkg::TIME_W-1:0]    stamp_ns;
   logic [ssd_pkg::TIME_W-1:0]    tag_out;
   logic [ssd_pkg::BUDGET_W-1:0]  deadline_ns;
   logic                          expired;

   modport source (output valid, accepted, journal_valid, prior_state, new_state,
                   cause_out, stamp_ns, tag_out, deadline_ns, expired,
                   input ready);
   modport sink (input valid, accepted, journal_valid, prior_state, new_state,
                 cause_out, stamp_ns, tag_out, deadline_ns, expired,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/ssd_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_step: one sequencer step
// Edge check, budget selection and deadline compare for one word; yields the
// journal word and the state update.
// ----------------------------------------------------------------------------
module ssd_step (
   input  wire logic                          action,
   input  wire logic [ssd_pkg::STATE_W-1:0]   target_state,
   input  wire logic [ssd_pkg::CAUSE_W-1:0]   cause,
   input  wire logic [ssd_pkg::TIME_W-1:0]    now_ns,
   input  wire logic [ssd_pkg::TIME_W-1:0]    request_tag,
   input  wire logic [ssd_pkg::STATE_W-1:0]   cur_state,
   input  wire logic [ssd_pkg::TIME_W-1:0]    entered_ns,
   input  wire logic [ssd_pkg::BUDGET_W-1:0]  budget_short,
   input  wire logic [ssd_pkg::BUDGET_W-1:0]  budget_bringup,
   input  wire logic [ssd_pkg::BUDGET_W-1:0]  budget_long,
   input  wire logic [ssd_pkg::BUDGET_W-1:0]  budget_recover,
   output ssd_pkg::rsp_word_type              word,
   output ssd_pkg::state_update_type          upd
);

   logic [ssd_pkg::BUDGET_W-1:0] budget;
   logic [ssd_pkg::TIME_W-1:0]   elapsed;
   logic [31:0]                  legal_mask;
   logic                         legal;
   logic                         fire;

   always_comb begin
      unique case (ssd_pkg::budget_class(cur_state))
         ssd_pkg::BC_SHORT:   budget = budget_short;
         ssd_pkg::BC_BRINGUP: budget = budget_bringup;
         ssd_pkg::BC_LONG:    budget = budget_long;
         ssd_pkg::BC_RECOVER: budget = budget_recover;
         default:             budget = '0;
      endcase
   end

   assign elapsed    = now_ns - entered_ns;
   assign legal_mask = ssd_pkg::legal_next(cur_state);
   assign legal      = (target_state < ssd_pkg::NUM_STATES) && legal_mask[target_state];
   assign fire       = (budget != '0) && (now_ns > entered_ns)
                     && (elapsed >= {{(ssd_pkg::TIME_W-ssd_pkg::BUDGET_W){1'b0}}, budget})
                     && ssd_pkg::has_recovery(cur_state);

   always_comb begin
      word             = '0;
      word.prior_state = cur_state;
      word.deadline_ns = budget;
      upd              = '0;
      upd.state        = cur_state;
      upd.entered_ns   = entered_ns;
      if (action == ssd_pkg::ACT_REQUEST) begin
         if (target_state != cur_state) begin
            word.journal_valid = 1'b1;
            word.new_state     = target_state;
            word.cause_out     = cause;
            word.stamp_ns      = now_ns;
            word.tag_out       = request_tag;
            if (legal) begin
               word.accepted  = 1'b1;
               upd.take       = 1'b1;
               upd.state      = target_state;
               upd.entered_ns = now_ns;
            end
         end
      end else if (fire) begin
         word.accepted      = 1'b1;
         word.journal_valid = 1'b1;
         word.new_state     = ssd_pkg::recovery_to(cur_state);
         word.cause_out     = ssd_pkg::CAUSE_TIMEOUT;
         word.stamp_ns      = now_ns;
         word.expired       = 1'b1;
         upd.take           = 1'b1;
         upd.state          = ssd_pkg::recovery_to(cur_state);
         upd.entered_ns     = now_ns;
      end
   end

endmodule
`default_nettype wire

// File: rtl/session_sequencer_with_deadlines_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// session_sequencer_with_deadlines_top: session lifecycle sequencer
// Nineteen-state sequencer with per-state deadline budgets and a journal word
// for every transition request and every fired deadline.
// ----------------------------------------------------------------------------
// One request word is taken every clock cycle while req_chan.ready is high and yields
// exactly one response word, held in the output stage or, while that is occupied, in
// the skid stage. State and entry time update on acceptance, so back-to-back words see
// the previous word's outcome. The cycle is set by the 64-bit elapsed-time subtract and
// compare against the selected 48-bit budget. A two-word output buffer keeps req_chan.ready
// high while one response waits; ready drops only when two responses are held. Budgets
// must be written through the csr_ port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module session_sequencer_with_deadlines_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ssd_req_if.sink                               req_chan,
   ssd_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [ssd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ssd_pkg::BUDGET_W-1:0]     csr_wdata
);

   logic [ssd_pkg::BUDGET_W-1:0] budget_short_ff;
   logic [ssd_pkg::BUDGET_W-1:0] budget_bringup_ff;
   logic [ssd_pkg::BUDGET_W-1:0] budget_long_ff;
   logic [ssd_pkg::BUDGET_W-1:0] budget_recover_ff;

   logic [ssd_pkg::STATE_W-1:0]  state_ff;
   logic [ssd_pkg::TIME_W-1:0]   entered_ff;

   ssd_pkg::rsp_word_type        out_ff;
   ssd_pkg::rsp_word_type        skid_ff;
   logic                         out_valid_ff;
   logic                         skid_valid_ff;
   logic                         out_valid_in;
   logic                         skid_valid_in;

   ssd_pkg::rsp_word_type        step_word;
   ssd_pkg::state_update_type    step_upd;
   logic                         push;
   logic                         pop;

   ssd_step u_step (
      .action         (req_chan.action),
      .target_state   (req_chan.target_state),
      .cause          (req_chan.cause),
      .now_ns         (req_chan.now_ns),
      .request_tag    (req_chan.request_tag),
      .cur_state      (state_ff),
      .entered_ns     (entered_ff),
      .budget_short   (budget_short_ff),
      .budget_bringup (budget_bringup_ff),
      .budget_long    (budget_long_ff),
      .budget_recover (budget_recover_ff),
      .word           (step_word),
      .upd            (step_upd)
   );

   assign req_chan.ready = !skid_valid_ff;
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_short_ff   <= ssd_pkg::RST_BUDGET_SHORT;
         budget_bringup_ff <= ssd_pkg::RST_BUDGET_BRINGUP;
         budget_long_ff    <= ssd_pkg::RST_BUDGET_LONG;
         budget_recover_ff <= ssd_pkg::RST_BUDGET_RECOVER;
      end else if (csr_we) begin
         unique case (csr_index)
            ssd_pkg::CSR_BUDGET_SHORT:   budget_short_ff   <= csr_wdata;
            ssd_pkg::CSR_BUDGET_BRINGUP: budget_bringup_ff <= csr_wdata;
            ssd_pkg::CSR_BUDGET_LONG:    budget_long_ff    <= csr_wdata;
            ssd_pkg::CSR_BUDGET_RECOVER: budget_recover_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ssd_pkg::ST_OFF;
         entered_ff <= '0;
      end else if (push && step_upd.take) begin
         state_ff   <= step_upd.state;
         entered_ff <= step_upd.entered_ns;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // load the output word from the skid stage or straight from the step logic
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= step_word;
         end else begin
            out_ff <= step_word;
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.accepted      = out_ff.accepted;
   assign rsp_chan.journal_valid = out_ff.journal_valid;
   assign rsp_chan.prior_state   = out_ff.prior_state;
   assign rsp_chan.new_state     = out_ff.new_state;
   assign rsp_chan.cause_out     = out_ff.cause_out;
   assign rsp_chan.stamp_ns      = out_ff.stamp_ns;
   assign rsp_chan.tag_out       = out_ff.tag_out;
   assign rsp_chan.deadline_ns   = out_ff.deadline_ns;
   assign rsp_chan.expired       = out_ff.expired;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a word while the output stage is empty");

   a_state_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff < ssd_pkg::NUM_STATES)
      else $error("sequencer state out of range");

   a_state_follows_step: assert property (@(posedge clock) disable iff (reset)
      (push && step_upd.take) |=> (state_ff == $past(step_upd.state)))
      else $error("state register missed a taken transition");

   a_hold_without_take: assert property (@(posedge clock) disable iff (reset)
      !(push && step_upd.take) |=> $stable(state_ff) && $stable(entered_ff))
      else $error("state moved without a taken transition");

   a_expired_record: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.expired) |->
         (rsp_chan.journal_valid && rsp_chan.accepted
          && rsp_chan.cause_out == ssd_pkg::CAUSE_TIMEOUT && rsp_chan.tag_out == '0))
      else $error("expired word is not a forced timeout record");

endmodule
`default_nettype wire
